// ===== src/avs_pkg.sv =====
`timescale 1ns / 1ps

package avs_pkg;

    // Samples per average, clamped to at least one.
    localparam int unsigned SAMPLE_COUNT = 10;
    localparam int unsigned BLOCK_LEN    = (SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT;
    localparam int unsigned ROUND_HALF   = BLOCK_LEN / 2;

    localparam int unsigned ADC_W  = 12;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned V_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Request codes on the op field.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Average: (sum + n/2) / n through a reciprocal multiply and one correction step.
    localparam int unsigned NUM_W       = SUM_W + 1;
    localparam int unsigned AVG_W       = ADC_W;
    localparam int unsigned Q1_W        = AVG_W + 1;
    localparam int unsigned AVG_SHIFT   = 20;
    localparam int unsigned AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int unsigned AVG_PROD_W  = NUM_W + AVG_RECIP_W;
    localparam int unsigned AVG_REM_W   = NUM_W + 1;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'((64'd1 << AVG_SHIFT) / 64'(BLOCK_LEN));

    // Scaling: (avg * full_scale + 2047) / 4095, again by reciprocal and correction.
    localparam int unsigned ADC_FULL    = 4095;
    localparam int unsigned ADC_HALF    = ADC_FULL / 2;
    localparam int unsigned VNUM_W      = AVG_W + V_W + 1;
    localparam int unsigned V_SHIFT     = 40;
    localparam int unsigned V_RECIP_W   = 29;
    localparam int unsigned V_PROD_W    = VNUM_W + V_RECIP_W;
    localparam int unsigned Q2_W        = V_W + 1;
    localparam int unsigned V_REM_W     = VNUM_W + 1;
    localparam logic [63:0] V_RECIP_FULL = (64'd1 << V_SHIFT) / 64'(ADC_FULL);
    localparam logic [V_RECIP_W-1:0] V_RECIP = V_RECIP_W'(V_RECIP_FULL);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE  = 3'd0,
        CFG_UV_LIMIT    = 3'd1,
        CFG_UV_RECOVERY = 3'd2,
        CFG_OV_LIMIT    = 3'd3,
        CFG_OV_RECOVERY = 3'd4
    } cfg_idx_t;

    localparam logic [V_W-1:0] RST_FULL_SCALE  = 16'd2000;
    localparam logic [V_W-1:0] RST_UV_LIMIT    = 16'd1050;
    localparam logic [V_W-1:0] RST_UV_RECOVERY = 16'd1100;
    localparam logic [V_W-1:0] RST_OV_LIMIT    = 16'd1350;
    localparam logic [V_W-1:0] RST_OV_RECOVERY = 16'd1300;

    typedef struct packed {
        logic [V_W-1:0] full_scale;
        logic [V_W-1:0] uv_limit;
        logic [V_W-1:0] uv_recovery;
        logic [V_W-1:0] ov_limit;
        logic [V_W-1:0] ov_recovery;
    } avs_cfg_t;

    typedef struct packed {
        logic [V_W-1:0] volts;
        logic           under;
        logic           over;
        logic           alarm;
        logic           under_chg;
        logic           over_chg;
    } avs_result_t;

endpackage

// ===== src/avs_accum.sv =====
`timescale 1ns / 1ps

module avs_accum
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [avs_pkg::ADC_W-1:0]      adc_sample,
    output logic                           num_valid,
    input  logic                           num_ready,
    output logic [avs_pkg::NUM_W-1:0]      num
);

    logic [avs_pkg::SUM_W-1:0] total_reg, total_next;
    logic [avs_pkg::CNT_W-1:0] count_reg, count_next;
    logic [avs_pkg::NUM_W-1:0] num_reg, num_next;
    logic                      num_valid_reg, num_valid_next;
    logic [avs_pkg::SUM_W-1:0] sum;
    logic                      accept;
    logic                      last;

    assign in_ready = !num_valid_reg || num_ready;
    assign accept   = in_valid && in_ready;
    assign sum      = total_reg + avs_pkg::SUM_W'(adc_sample);
    assign last     = (count_reg == avs_pkg::CNT_W'(avs_pkg::BLOCK_LEN - 1));

    always_comb
    begin
        total_next     = total_reg;
        count_next     = count_reg;
        num_next       = num_reg;
        num_valid_next = num_valid_reg && !num_ready;
        if (accept)
        begin
            if (op == avs_pkg::OP_RESTART)
            begin
                total_next = '0;
                count_next = '0;
            end
            else if (last)
            begin
                total_next     = '0;
                count_next     = '0;
                num_next       = avs_pkg::NUM_W'(sum) + avs_pkg::NUM_W'(avs_pkg::ROUND_HALF);
                num_valid_next = 1'b1;
            end
            else
            begin
                total_next = sum;
                count_next = count_reg + avs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            count_reg     <= '0;
            num_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            count_reg     <= count_next;
            num_valid_reg <= num_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
    end

    assign num_valid = num_valid_reg;
    assign num       = num_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= avs_pkg::CNT_W'(avs_pkg::BLOCK_LEN - 1))
        else $error("sample count passed the block length");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == avs_pkg::OP_RESTART) |=> (total_reg == '0 && count_reg == '0))
        else $error("restart did not clear the accumulator");

endmodule

// ===== src/avs_avg_div.sv =====
`timescale 1ns / 1ps

module avs_avg_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [avs_pkg::NUM_W-1:0]     num,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [avs_pkg::AVG_W-1:0]     avg
);

    logic                            v2_reg, v3_reg;
    logic                            rdy2, rdy3;
    logic [avs_pkg::NUM_W-1:0]       num2_reg;
    logic [avs_pkg::Q1_W-1:0]        q1_reg, q1_next;
    logic [avs_pkg::AVG_W-1:0]       avg_reg, avg_next;
    logic [avs_pkg::AVG_PROD_W-1:0]  prod;
    logic [avs_pkg::AVG_REM_W-1:0]   rem;
    logic [avs_pkg::Q1_W-1:0]        q_fix;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // Estimate is exact or one short.
    always_comb
    begin
        prod    = avs_pkg::AVG_PROD_W'(num) * avs_pkg::AVG_PROD_W'(avs_pkg::AVG_RECIP);
        q1_next = prod[avs_pkg::AVG_SHIFT +: avs_pkg::Q1_W];
    end

    always_comb
    begin
        rem = avs_pkg::AVG_REM_W'(num2_reg)
            - avs_pkg::AVG_REM_W'(q1_reg) * avs_pkg::AVG_REM_W'(avs_pkg::BLOCK_LEN);
        if (rem >= avs_pkg::AVG_REM_W'(avs_pkg::BLOCK_LEN))
            q_fix = q1_reg + avs_pkg::Q1_W'(1);
        else
            q_fix = q1_reg;
        avg_next = q_fix[avs_pkg::AVG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                v2_reg <= in_valid;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            num2_reg <= num;
            q1_reg   <= q1_next;
        end
        if (rdy3)
            avg_reg <= avg_next;
    end

    assign out_valid = v3_reg;
    assign avg       = avg_reg;

endmodule

// ===== src/avs_scale.sv =====
`timescale 1ns / 1ps

module avs_scale
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  avs_pkg::avs_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [avs_pkg::AVG_W-1:0]    avg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [avs_pkg::V_W-1:0]      volts
);

    logic                          v4_reg, v5_reg, v6_reg;
    logic                          rdy4, rdy5, rdy6;
    logic [avs_pkg::VNUM_W-1:0]    x4_reg, x4_next, x5_reg;
    logic [avs_pkg::Q2_W-1:0]      q2_reg, q2_next, q_fix;
    logic [avs_pkg::V_W-1:0]       volts_reg, volts_next;
    logic [avs_pkg::V_PROD_W-1:0]  prod;
    logic [avs_pkg::V_REM_W-1:0]   qm;
    logic [avs_pkg::V_REM_W-1:0]   rem;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    assign x4_next = avs_pkg::VNUM_W'(avg) * avs_pkg::VNUM_W'(cfg.full_scale)
                   + avs_pkg::VNUM_W'(avs_pkg::ADC_HALF);

    always_comb
    begin
        prod    = avs_pkg::V_PROD_W'(x4_reg) * avs_pkg::V_PROD_W'(avs_pkg::V_RECIP);
        q2_next = prod[avs_pkg::V_SHIFT +: avs_pkg::Q2_W];
    end

    // The divisor is 2^12 - 1, so q * 4095 is a shift and a subtract.
    always_comb
    begin
        qm  = (avs_pkg::V_REM_W'(q2_reg) << avs_pkg::ADC_W) - avs_pkg::V_REM_W'(q2_reg);
        rem = avs_pkg::V_REM_W'(x5_reg) - qm;
        if (rem >= avs_pkg::V_REM_W'(avs_pkg::ADC_FULL))
            q_fix = q2_reg + avs_pkg::Q2_W'(1);
        else
            q_fix = q2_reg;
        volts_next = q_fix[avs_pkg::V_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= in_valid;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
            x4_reg <= x4_next;
        if (rdy5)
        begin
            x5_reg <= x4_reg;
            q2_reg <= q2_next;
        end
        if (rdy6)
            volts_reg <= volts_next;
    end

    assign out_valid = v6_reg;
    assign volts     = volts_reg;

endmodule

// ===== src/avs_hyst.sv =====
`timescale 1ns / 1ps

module avs_hyst
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  avs_pkg::avs_cfg_t          cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [avs_pkg::V_W-1:0]    volts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output avs_pkg::avs_result_t       res
);

    logic                  under_reg, under_next;
    logic                  over_reg, over_next;
    logic                  out_valid_reg;
    avs_pkg::avs_result_t  res_reg, res_next;
    logic                  load;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // A clear flag tests only its limit, a set flag only its recovery level.
    always_comb
    begin
        if (under_reg)
            under_next = !(volts >= cfg.uv_recovery);
        else
            under_next = (volts < cfg.uv_limit);
        if (over_reg)
            over_next = !(volts <= cfg.ov_recovery);
        else
            over_next = (volts > cfg.ov_limit);
        res_next.volts     = volts;
        res_next.under     = under_next;
        res_next.over      = over_next;
        res_next.alarm     = under_next || over_next;
        res_next.under_chg = under_next != under_reg;
        res_next.over_chg  = over_next != over_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            under_reg     <= 1'b0;
            over_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                out_valid_reg <= in_valid;
            if (load)
            begin
                under_reg <= under_next;
                over_reg  <= over_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_alarm_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.alarm == (res_reg.under || res_reg.over)))
        else $error("alarm level does not match the flags");

    a_under_event: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res_reg.under_chg == (under_reg != $past(under_reg))))
        else $error("undervoltage event does not match the flag change");

    a_over_event: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (res_reg.over_chg == (over_reg != $past(over_reg))))
        else $error("overvoltage event does not match the flag change");

endmodule

// ===== src/averaging_voltage_supervisor_top.sv =====
`timescale 1ns / 1ps
// A result passes the accumulator, average division, scaling and flag registers in order.
// Throughput: one sample request per cycle, sustained; the seven register stages
// (accumulator, two for the average division, three for scaling, one for the flags)
// each hold one request, so back-pressure only stops input once every stage is full.
// Reset (rst_n, asynchronous, active low): the configuration returns to its defaults,
// accumulator and flags clear and the pipeline empties; no clearing pass is needed.

module averaging_voltage_supervisor_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [avs_pkg::ADC_W-1:0]         adc_sample,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [avs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avs_pkg::V_W-1:0]           cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [avs_pkg::V_W-1:0]           volts_hundredths,
    output logic                              under_flag,
    output logic                              over_flag,
    output logic                              alarm_level,
    output logic                              under_changed,
    output logic                              over_changed
);

    avs_pkg::avs_cfg_t     cfg_reg, cfg_next;
    avs_pkg::avs_result_t  res;
    logic                              num_valid, num_ready;
    logic [avs_pkg::NUM_W-1:0]         num;
    logic                              avg_valid, avg_ready;
    logic [avs_pkg::AVG_W-1:0]         avg;
    logic                              volts_valid, volts_ready;
    logic [avs_pkg::V_W-1:0]           volts;

    // Configuration writes are always taken; the host must only write while idle,
    // which the block does not enforce. A write to an unused index is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (avs_pkg::cfg_idx_t'(cfg_index))
                avs_pkg::CFG_FULL_SCALE:  cfg_next.full_scale  = cfg_data;
                avs_pkg::CFG_UV_LIMIT:    cfg_next.uv_limit    = cfg_data;
                avs_pkg::CFG_UV_RECOVERY: cfg_next.uv_recovery = cfg_data;
                avs_pkg::CFG_OV_LIMIT:    cfg_next.ov_limit    = cfg_data;
                avs_pkg::CFG_OV_RECOVERY: cfg_next.ov_recovery = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale  <= avs_pkg::RST_FULL_SCALE;
            cfg_reg.uv_limit    <= avs_pkg::RST_UV_LIMIT;
            cfg_reg.uv_recovery <= avs_pkg::RST_UV_RECOVERY;
            cfg_reg.ov_limit    <= avs_pkg::RST_OV_LIMIT;
            cfg_reg.ov_recovery <= avs_pkg::RST_OV_RECOVERY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sample requests are summed here; a restart request clears the running sum
    // and count but leaves the flags alone. Only the request that completes a
    // block passes a rounded numerator down the pipeline.
    avs_accum u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .adc_sample (adc_sample),
        .num_valid  (num_valid),
        .num_ready  (num_ready),
        .num        (num)
    );

    // Division by the block length: reciprocal multiply, then one correction.
    avs_avg_div u_avg_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .num       (num),
        .out_valid (avg_valid),
        .out_ready (avg_ready),
        .avg       (avg)
    );

    // Conversion to hundredths of a volt with rounding.
    avs_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (avg_valid),
        .in_ready  (avg_ready),
        .avg       (avg),
        .out_valid (volts_valid),
        .out_ready (volts_ready),
        .volts     (volts)
    );

    // Hysteresis flags and the output register.
    avs_hyst u_hyst
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (volts_valid),
        .in_ready  (volts_ready),
        .volts     (volts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign volts_hundredths = res.volts;
    assign under_flag       = res.under;
    assign over_flag        = res.over;
    assign alarm_level      = res.alarm;
    assign under_changed    = res.under_chg;
    assign over_changed     = res.over_chg;

endmodule

// ===== test/averaging_voltage_supervisor_top_tb.sv =====
`timescale 1ns / 1ps

module averaging_voltage_supervisor_top_tb;

    // Register indexes beyond the last real register; writes to them must be ignored.
    localparam int unsigned CFG_UNUSED_LO = 5;
    localparam int unsigned CFG_UNUSED_HI = 7;

    // Samples per average as the block sees it, clamped to at least one.
    localparam int unsigned BLOCK_N =
        (avs_pkg::SAMPLE_COUNT < 1) ? 1 : avs_pkg::SAMPLE_COUNT;
    localparam int unsigned ADC_MAX = 4095;

    // Generous bound on the length of the whole run.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct {
        logic                       op;
        logic [avs_pkg::ADC_W-1:0]  sample;
    } supervisor_request_t;

    typedef struct {
        logic [avs_pkg::CFG_IDX_W-1:0] index;
        logic [avs_pkg::V_W-1:0]       data;
    } register_write_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          op = avs_pkg::OP_SAMPLE;
    logic [avs_pkg::ADC_W-1:0]     adc_sample = '0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [avs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [avs_pkg::V_W-1:0]       cfg_data = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [avs_pkg::V_W-1:0]       volts_hundredths;
    logic                          under_flag;
    logic                          over_flag;
    logic                          alarm_level;
    logic                          under_changed;
    logic                          over_changed;

    averaging_voltage_supervisor_top dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .adc_sample       (adc_sample),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .volts_hundredths (volts_hundredths),
        .under_flag       (under_flag),
        .over_flag        (over_flag),
        .alarm_level      (alarm_level),
        .under_changed    (under_changed),
        .over_changed     (over_changed)
    );

    always #2 clk = ~clk;

    // Requests and register writes waiting to be offered, and the readings that the
    // accepted requests are predicted to produce, oldest first.
    supervisor_request_t   pending_requests[$];
    register_write_t       pending_writes[$];
    avs_pkg::avs_result_t  expected_readings[$];

    int unsigned requests_queued = 0;
    int unsigned requests_accepted = 0;
    int unsigned writes_queued = 0;
    int unsigned writes_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    // When set, neither side inserts idle cycles.
    bit no_gaps = 1'b0;

    // The testbench's own copy of the registers and of the accumulator and flags.
    logic [avs_pkg::V_W-1:0]   full_scale_reg;
    logic [avs_pkg::V_W-1:0]   uv_limit_reg;
    logic [avs_pkg::V_W-1:0]   uv_recovery_reg;
    logic [avs_pkg::V_W-1:0]   ov_limit_reg;
    logic [avs_pkg::V_W-1:0]   ov_recovery_reg;
    logic [avs_pkg::SUM_W-1:0] acc_total;
    logic [avs_pkg::CNT_W-1:0] acc_count;
    logic [avs_pkg::V_W-1:0]   last_volts;
    logic                      under_state;
    logic                      over_state;

    supervisor_request_t next_request;
    register_write_t     next_write;

    // Gaps are taken with a chance of eight in a hundred, unless the quiet stretch is on.
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < 8);
    endfunction

    function automatic void load_register(logic [avs_pkg::CFG_IDX_W-1:0] index,
                                          logic [avs_pkg::V_W-1:0] data);
        case (index)
            avs_pkg::CFG_FULL_SCALE:  full_scale_reg  = data;
            avs_pkg::CFG_UV_LIMIT:    uv_limit_reg    = data;
            avs_pkg::CFG_UV_RECOVERY: uv_recovery_reg = data;
            avs_pkg::CFG_OV_LIMIT:    ov_limit_reg    = data;
            avs_pkg::CFG_OV_RECOVERY: ov_recovery_reg = data;
            default:                  ;
        endcase
    endfunction

    // Accumulates one accepted request and, when it completes an average, queues the
    // reading that the block should emit. A restart clears the accumulator and the
    // voltage but leaves both flags alone.
    function automatic void supervise(logic req_op, logic [avs_pkg::ADC_W-1:0] sample);
        logic [31:0] avg;
        logic [31:0] prod;
        avs_pkg::avs_result_t reading;
        if (req_op == avs_pkg::OP_RESTART)
        begin
            acc_total  = '0;
            acc_count  = '0;
            last_volts = '0;
            return;
        end
        acc_total = acc_total + avs_pkg::SUM_W'(sample);
        acc_count = acc_count + avs_pkg::CNT_W'(1);
        if (acc_count < BLOCK_N)
            return;
        avg = (32'(acc_total) + BLOCK_N / 2) / BLOCK_N;
        prod = avg * 32'(full_scale_reg);
        last_volts = avs_pkg::V_W'((prod + ADC_MAX / 2) / ADC_MAX);
        acc_total = '0;
        acc_count = '0;
        reading.under_chg = 1'b0;
        reading.over_chg  = 1'b0;
        // Each flag is tested once: a clear flag only against its limit, a set flag
        // only against its recovery level, even when the two are inverted.
        if (under_state)
        begin
            if (last_volts >= uv_recovery_reg)
            begin
                under_state = 1'b0;
                reading.under_chg = 1'b1;
            end
        end
        else if (last_volts < uv_limit_reg)
        begin
            under_state = 1'b1;
            reading.under_chg = 1'b1;
        end
        if (over_state)
        begin
            if (last_volts <= ov_recovery_reg)
            begin
                over_state = 1'b0;
                reading.over_chg = 1'b1;
            end
        end
        else if (last_volts > ov_limit_reg)
        begin
            over_state = 1'b1;
            reading.over_chg = 1'b1;
        end
        reading.volts = last_volts;
        reading.under = under_state;
        reading.over  = over_state;
        reading.alarm = under_state | over_state;
        expected_readings.push_back(reading);
    endfunction

    function automatic void compare_field(string name, logic [avs_pkg::V_W-1:0] want,
                                          logic [avs_pkg::V_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Request driver. The accepted request is fed to the predictor using the values
    // that were on the port before this edge; a new request, if any, goes out with a
    // single assignment to in_valid so that valid never drops between back-to-back
    // requests.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                supervise(op, adc_sample);
                requests_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && !take_gap())
                begin
                    next_request = pending_requests.pop_front();
                    in_valid   <= 1'b1;
                    op         <= next_request.op;
                    adc_sample <= next_request.sample;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver, the same scheme on the configuration channel.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                load_register(cfg_index, cfg_data);
                writes_accepted++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (pending_writes.size() != 0 && !take_gap())
                begin
                    next_write = pending_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.index;
                    cfg_data  <= next_write.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Reading monitor. Back-pressure is applied at random and every accepted reading
    // is checked field by field against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !take_gap();
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t ns: unexpected reading, expected none, actual volts %0d",
                             $time, volts_hundredths);
                    mismatches++;
                end
                else
                begin
                    compare_field("volts_hundredths", expected_readings[0].volts,
                                  volts_hundredths);
                    compare_field("under_flag", avs_pkg::V_W'(expected_readings[0].under),
                                  avs_pkg::V_W'(under_flag));
                    compare_field("over_flag", avs_pkg::V_W'(expected_readings[0].over),
                                  avs_pkg::V_W'(over_flag));
                    compare_field("alarm_level", avs_pkg::V_W'(expected_readings[0].alarm),
                                  avs_pkg::V_W'(alarm_level));
                    compare_field("under_changed",
                                  avs_pkg::V_W'(expected_readings[0].under_chg),
                                  avs_pkg::V_W'(under_changed));
                    compare_field("over_changed",
                                  avs_pkg::V_W'(expected_readings[0].over_chg),
                                  avs_pkg::V_W'(over_changed));
                    void'(expected_readings.pop_front());
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("averaging_voltage_supervisor_top_tb NOT OK");
            $finish;
        end
    end

    task automatic push_request(logic req_op, int unsigned sample);
        supervisor_request_t req;
        req.op = req_op;
        req.sample = avs_pkg::ADC_W'(sample);
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic push_write(int unsigned index, int unsigned data);
        register_write_t wr;
        wr.index = avs_pkg::CFG_IDX_W'(index);
        wr.data = avs_pkg::V_W'(data);
        pending_writes.push_back(wr);
        writes_queued++;
    endtask

    // A full average's worth of samples scattered around one level, so that the
    // resulting voltage can be steered across the thresholds.
    task automatic push_block(int level, int spread);
        int v;
        for (int i = 0; i < BLOCK_N; i++)
        begin
            v = level + int'($urandom_range(2 * spread)) - spread;
            if (v < 0)
                v = 0;
            if (v > ADC_MAX)
                v = ADC_MAX;
            push_request(avs_pkg::OP_SAMPLE, v);
        end
    endtask

    // Waits until everything queued has been accepted and every predicted reading has
    // arrived, then lets the pipeline empty of requests that produce no reading.
    task automatic settle();
        int unsigned guard;
        while (requests_accepted != requests_queued || writes_accepted != writes_queued)
            @(posedge clk);
        guard = 0;
        while (expected_readings.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_readings.size() != 0)
        begin
            $display("%0t ns: missing readings, expected %0d more, actual 0", $time,
                     expected_readings.size());
            mismatches++;
            expected_readings.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers, plus one write to an unused index carrying random
    // data, which the block must ignore. Only called while the block is idle.
    task automatic program_registers(int unsigned full_scale, int unsigned uvl,
                                     int unsigned uvr, int unsigned ovl, int unsigned ovr);
        push_write(avs_pkg::CFG_FULL_SCALE, full_scale);
        push_write(avs_pkg::CFG_UV_LIMIT, uvl);
        push_write(CFG_UNUSED_LO + $urandom_range(CFG_UNUSED_HI - CFG_UNUSED_LO),
                   $urandom_range(16'hFFFF));
        push_write(avs_pkg::CFG_UV_RECOVERY, uvr);
        push_write(avs_pkg::CFG_OV_LIMIT, ovl);
        push_write(avs_pkg::CFG_OV_RECOVERY, ovr);
        settle();
    endtask

    // Random traffic. Most of it is whole averages around a random level so that the
    // flags move through their hysteresis bands; the rest is single random samples,
    // restarts and averages broken off by a restart.
    task automatic random_traffic(int unsigned budget);
        int unsigned queued;
        int unsigned pick;
        int unsigned part;
        queued = 0;
        while (queued < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                push_block($urandom_range(ADC_MAX),
                           ($urandom_range(9) == 0) ? ADC_MAX / 2 : $urandom_range(40));
                queued += BLOCK_N;
            end
            else if (pick < 88)
            begin
                push_request(avs_pkg::OP_SAMPLE, $urandom_range(ADC_MAX));
                queued++;
            end
            else if (pick < 95)
            begin
                // The sample field of a restart carries junk on purpose.
                push_request(avs_pkg::OP_RESTART, $urandom_range(ADC_MAX));
                queued++;
            end
            else
            begin
                part = $urandom_range(BLOCK_N - 1, 1);
                for (int i = 0; i < part; i++)
                    push_request(avs_pkg::OP_SAMPLE, $urandom_range(ADC_MAX));
                push_request(avs_pkg::OP_RESTART, $urandom_range(ADC_MAX));
                queued += part + 1;
            end
        end
        settle();
    endtask

    // Random register set: a random full scale with thresholds spread over the range
    // that the voltage can reach, in any order, so inverted windows also turn up.
    task automatic random_registers();
        int unsigned fs;
        fs = $urandom_range(16'hFFFF);
        program_registers(fs, $urandom_range(fs), $urandom_range(fs),
                          $urandom_range(fs), $urandom_range(fs));
    endtask

    initial
    begin
        // Register copy and accumulator as the block has them after reset.
        full_scale_reg  = avs_pkg::RST_FULL_SCALE;
        uv_limit_reg    = avs_pkg::RST_UV_LIMIT;
        uv_recovery_reg = avs_pkg::RST_UV_RECOVERY;
        ov_limit_reg    = avs_pkg::RST_OV_LIMIT;
        ov_recovery_reg = avs_pkg::RST_OV_RECOVERY;
        acc_total   = '0;
        acc_count   = '0;
        last_volts  = '0;
        under_state = 1'b0;
        over_state  = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values. A block of zeros drives the
        // voltage to the bottom and raises undervoltage; a block of full-scale codes
        // clears it and raises overvoltage; a short run broken off by a restart must
        // produce nothing and leave both flags as they were.
        for (int i = 0; i < BLOCK_N; i++)
            push_request(avs_pkg::OP_SAMPLE, 0);
        for (int i = 0; i < BLOCK_N; i++)
            push_request(avs_pkg::OP_SAMPLE, ADC_MAX);
        push_request(avs_pkg::OP_SAMPLE, ADC_MAX);
        push_request(avs_pkg::OP_SAMPLE, 1);
        push_request(avs_pkg::OP_RESTART, ADC_MAX);
        settle();

        // Largest full scale, thresholds pinned at the ends of the range.
        program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
        random_traffic(200);

        // Zero full scale: the voltage is always zero.
        program_registers(0, 0, 0, 16'hFFFF, 16'hFFFF);
        random_traffic(150);

        // Inverted thresholds on both flags.
        program_registers(ADC_MAX, 2500, 1500, 1500, 2500);
        random_traffic(200);

        // A stretch with no idle cycles on either side.
        random_registers();
        no_gaps = 1'b1;
        random_traffic(250);
        no_gaps = 1'b0;

        random_registers();
        random_traffic(200);

        // Back to the reset values, written explicitly.
        program_registers(avs_pkg::RST_FULL_SCALE, avs_pkg::RST_UV_LIMIT,
                          avs_pkg::RST_UV_RECOVERY, avs_pkg::RST_OV_LIMIT,
                          avs_pkg::RST_OV_RECOVERY);
        random_traffic(200);

        if (mismatches == 0)
            $display("averaging_voltage_supervisor_top_tb OK");
        else
            $display("averaging_voltage_supervisor_top_tb NOT OK");
        $finish;
    end

endmodule
